// ===== sv/dws_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and constants of the display window write sequencer
// no dependencies; every other file but dws_tb_pkg refers to this package by scoped names

package dws_pkg;

   typedef logic [9:0]  coord_type;
   typedef logic [8:0]  dim_type;
   typedef logic [15:0] pixel_type;
   typedef logic [7:0]  byte_type;
   typedef logic [16:0] count_type;
   typedef logic [7:0]  reg_index_type;

   localparam byte_type CMD_COL_SET = 8'h2A;
   localparam byte_type CMD_ROW_SET = 8'h2B;
   localparam byte_type CMD_MEM_WR  = 8'h2C;

   localparam reg_index_type REG_PANEL_WIDTH  = 8'd0;
   localparam reg_index_type REG_PANEL_HEIGHT = 8'd1;

   localparam dim_type   PANEL_WIDTH_RESET  = 9'd240;
   localparam dim_type   PANEL_HEIGHT_RESET = 9'd240;
   localparam count_type COUNT_MAX          = 17'h1FFFF;

   localparam int unsigned QUEUE_DEPTH = 4;

   // one classified item handed from the front to the back
   typedef struct packed {
      logic      is_pixel;
      dim_type   col_start;
      dim_type   col_end;
      dim_type   row_start;
      dim_type   row_end;
      pixel_type pixel;
      logic      done;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_START,
      ST_COL_SH,
      ST_COL_SL,
      ST_COL_EH,
      ST_COL_EL,
      ST_ROW_CMD,
      ST_ROW_SH,
      ST_ROW_SL,
      ST_ROW_EH,
      ST_ROW_EL,
      ST_MEM_WR,
      ST_PIX_HI
   } state_type;

endpackage

// ===== sv/dws_req_if.sv =====
`timescale 1ns / 1ps
// request channel: window and pixel items
// depends on dws_pkg

interface dws_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   dws_pkg::coord_type win_x;
   dws_pkg::coord_type win_y;
   dws_pkg::coord_type win_w;
   dws_pkg::coord_type win_h;
   dws_pkg::pixel_type pixel;

   modport source(output valid, func, win_x, win_y, win_w, win_h, pixel, input ready);
   modport sink(input valid, func, win_x, win_y, win_w, win_h, pixel, output ready);
endinterface

// ===== sv/dws_rsp_if.sv =====
`timescale 1ns / 1ps
// response channel: one wire byte per transfer with its line flags
// depends on dws_pkg

interface dws_rsp_if;
   logic              valid;
   logic              ready;
   dws_pkg::byte_type wire_byte;
   logic              is_data;
   logic              release_select;
   logic              last_of_run;

   modport source(output valid, wire_byte, is_data, release_select, last_of_run, input ready);
   modport sink(input valid, wire_byte, is_data, release_select, last_of_run, output ready);
endinterface

// ===== sv/dws_csr_if.sv =====
`timescale 1ns / 1ps
// register write channel: index and data
// depends on dws_pkg

interface dws_csr_if;
   logic                   valid;
   logic                   ready;
   dws_pkg::reg_index_type index;
   dws_pkg::dim_type       data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/dws_front.sv =====
`timescale 1ns / 1ps
// front end: panel size registers, window clipping, pixel counting
// depends on dws_pkg, dws_req_if, dws_csr_if

module dws_front (
   input  logic             clock,
   input  logic             reset,
   dws_req_if.sink          req_bus,
   dws_csr_if.sink          csr_bus,
   output logic             push_valid,
   output dws_pkg::cmd_type push_cmd,
   input  logic             push_ready
);

   dws_pkg::dim_type   width_ff, width_in;
   dws_pkg::dim_type   height_ff, height_in;
   dws_pkg::count_type left_ff, left_in;

   logic               a_valid_ff, a_valid_in;
   logic               a_is_pix_ff;
   logic               a_reject_ff;
   dws_pkg::dim_type   a_x_ff, a_xend_ff, a_w_ff;
   dws_pkg::dim_type   a_y_ff, a_yend_ff, a_h_ff;
   dws_pkg::pixel_type a_pixel_ff;

   logic [9:0]  pw, ph, wc, hc;
   logic [10:0] xsum, ysum, xend, yend;
   logic        clip_x, clip_y, reject;
   logic [17:0] area;
   logic        a_drop, a_advance, take;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            dws_pkg::REG_PANEL_WIDTH:  width_in  = csr_bus.data;
            dws_pkg::REG_PANEL_HEIGHT: height_in = csr_bus.data;
            default: ;
         endcase
      end
   end

   // clipping against the panel size
   always_comb begin
      pw     = {1'b0, width_ff};
      ph     = {1'b0, height_ff};
      reject = (req_bus.win_x >= pw) || (req_bus.win_y >= ph) ||
               (req_bus.win_w == '0) || (req_bus.win_h == '0);
      xsum   = {1'b0, req_bus.win_x} + {1'b0, req_bus.win_w};
      ysum   = {1'b0, req_bus.win_y} + {1'b0, req_bus.win_h};
      clip_x = xsum > {1'b0, pw};
      clip_y = ysum > {1'b0, ph};
      wc     = clip_x ? (pw - req_bus.win_x) : req_bus.win_w;
      hc     = clip_y ? (ph - req_bus.win_y) : req_bus.win_h;
      xend   = clip_x ? ({1'b0, pw} - 11'd1) : (xsum - 11'd1);
      yend   = clip_y ? ({1'b0, ph} - 11'd1) : (ysum - 11'd1);
   end

   // stray pixels and rejected windows leave without a queue slot
   assign area       = 18'(a_w_ff) * 18'(a_h_ff);
   assign a_drop     = a_is_pix_ff ? (left_ff == '0) : a_reject_ff;
   assign a_advance  = a_drop || push_ready;
   assign req_bus.ready = !a_valid_ff || a_advance;
   assign take       = req_bus.valid && req_bus.ready;
   assign push_valid = a_valid_ff && !a_drop;

   always_comb begin
      push_cmd.is_pixel  = a_is_pix_ff;
      push_cmd.col_start = a_x_ff;
      push_cmd.col_end   = a_xend_ff;
      push_cmd.row_start = a_y_ff;
      push_cmd.row_end   = a_yend_ff;
      push_cmd.pixel     = a_pixel_ff;
      push_cmd.done      = (left_ff == 17'd1);
   end

   always_comb begin
      left_in = left_ff;
      if (a_valid_ff && !a_drop && push_ready) begin
         if (a_is_pix_ff) begin
            left_in = left_ff - 17'd1;
         end else begin
            left_in = area[17] ? dws_pkg::COUNT_MAX : area[16:0];
         end
      end
   end

   assign a_valid_in = take ? 1'b1 : (a_advance ? 1'b0 : a_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= dws_pkg::PANEL_WIDTH_RESET;
         height_ff  <= dws_pkg::PANEL_HEIGHT_RESET;
         left_ff    <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         left_ff    <= left_in;
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         a_is_pix_ff <= req_bus.func;
         a_reject_ff <= reject;
         a_x_ff      <= req_bus.win_x[8:0];
         a_xend_ff   <= xend[8:0];
         a_w_ff      <= wc[8:0];
         a_y_ff      <= req_bus.win_y[8:0];
         a_yend_ff   <= yend[8:0];
         a_h_ff      <= hc[8:0];
         a_pixel_ff  <= req_bus.pixel;
      end
   end

endmodule

// ===== sv/dws_queue.sv =====
`timescale 1ns / 1ps
// small queue of classified items between front and back
// depends on dws_pkg

module dws_queue #(
   parameter int unsigned DEPTH = dws_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  dws_pkg::cmd_type push_cmd,
   output logic             push_ready,
   output logic             head_valid,
   output dws_pkg::cmd_type head_cmd,
   input  logic             pop
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   dws_pkg::cmd_type store [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = store[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== sv/dws_back.sv =====
`timescale 1ns / 1ps
// back end: byte sequencer and registered response stage
// depends on dws_pkg, dws_rsp_if

module dws_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  dws_pkg::cmd_type head_cmd,
   output logic             pop,
   dws_rsp_if.source        rsp_bus
);

   dws_pkg::state_type state_ff, state_in;
   logic               valid_ff, valid_in;
   dws_pkg::byte_type  byte_ff, byte_in;
   logic               data_ff, data_in;
   logic               rel_ff, rel_in;
   logic               last_ff, last_in;
   logic               go;
   logic [15:0]        cs, ce, rs, re;

   assign cs = 16'(head_cmd.col_start);
   assign ce = 16'(head_cmd.col_end);
   assign rs = 16'(head_cmd.row_start);
   assign re = 16'(head_cmd.row_end);

   // one byte per cycle whenever the queue holds an item and the output stage is free
   assign go = head_valid && (!valid_ff || rsp_bus.ready);

   always_comb begin
      state_in = state_ff;
      byte_in  = '0;
      data_in  = 1'b1;
      rel_in   = 1'b0;
      last_in  = 1'b0;
      pop      = 1'b0;
      if (go) begin
         unique case (state_ff)
            dws_pkg::ST_START: begin
               if (head_cmd.is_pixel) begin
                  byte_in  = head_cmd.pixel[7:0];
                  state_in = dws_pkg::ST_PIX_HI;
               end else begin
                  byte_in  = dws_pkg::CMD_COL_SET;
                  data_in  = 1'b0;
                  state_in = dws_pkg::ST_COL_SH;
               end
            end
            dws_pkg::ST_COL_SH: begin
               byte_in  = cs[15:8];
               state_in = dws_pkg::ST_COL_SL;
            end
            dws_pkg::ST_COL_SL: begin
               byte_in  = cs[7:0];
               state_in = dws_pkg::ST_COL_EH;
            end
            dws_pkg::ST_COL_EH: begin
               byte_in  = ce[15:8];
               state_in = dws_pkg::ST_COL_EL;
            end
            dws_pkg::ST_COL_EL: begin
               byte_in  = ce[7:0];
               rel_in   = 1'b1;
               state_in = dws_pkg::ST_ROW_CMD;
            end
            dws_pkg::ST_ROW_CMD: begin
               byte_in  = dws_pkg::CMD_ROW_SET;
               data_in  = 1'b0;
               state_in = dws_pkg::ST_ROW_SH;
            end
            dws_pkg::ST_ROW_SH: begin
               byte_in  = rs[15:8];
               state_in = dws_pkg::ST_ROW_SL;
            end
            dws_pkg::ST_ROW_SL: begin
               byte_in  = rs[7:0];
               state_in = dws_pkg::ST_ROW_EH;
            end
            dws_pkg::ST_ROW_EH: begin
               byte_in  = re[15:8];
               state_in = dws_pkg::ST_ROW_EL;
            end
            dws_pkg::ST_ROW_EL: begin
               byte_in  = re[7:0];
               rel_in   = 1'b1;
               state_in = dws_pkg::ST_MEM_WR;
            end
            dws_pkg::ST_MEM_WR: begin
               // chip select stays low for the pixels that follow
               byte_in  = dws_pkg::CMD_MEM_WR;
               data_in  = 1'b0;
               last_in  = 1'b1;
               pop      = 1'b1;
               state_in = dws_pkg::ST_START;
            end
            dws_pkg::ST_PIX_HI: begin
               byte_in  = head_cmd.pixel[15:8];
               rel_in   = head_cmd.done;
               last_in  = 1'b1;
               pop      = 1'b1;
               state_in = dws_pkg::ST_START;
            end
            default: begin
               state_in = dws_pkg::ST_START;
            end
         endcase
      end
   end

   assign valid_in = go ? 1'b1 : (rsp_bus.ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dws_pkg::ST_START;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         byte_ff <= byte_in;
         data_ff <= data_in;
         rel_ff  <= rel_in;
         last_ff <= last_in;
      end
   end

   assign rsp_bus.valid          = valid_ff;
   assign rsp_bus.wire_byte      = byte_ff;
   assign rsp_bus.is_data        = data_ff;
   assign rsp_bus.release_select = rel_ff;
   assign rsp_bus.last_of_run    = last_ff;

endmodule

// ===== sv/display_window_write_sequencer.sv =====
`timescale 1ns / 1ps
// channel   direction  carries
// req_bus   in         func, win_x, win_y, win_w, win_h, pixel
// rsp_bus   out        wire_byte, is_data, release_select, last_of_run
// csr_bus   in         index, data (0 panel_width, 1 panel_height)
//
// the sequencer sends a byte per cycle unless stalled; a window is 11 bytes, a pixel 2
// accepted items pass a front register and the queue before the response stage
// the queue of QUEUE_DEPTH items lets the front keep taking items while rsp_bus stalls
// dropped windows and stray pixels pass the front register and take no queue slot
// reset is synchronous: panel size 240 x 240, no pixels outstanding

module display_window_write_sequencer #(
   parameter int unsigned QUEUE_DEPTH = dws_pkg::QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   dws_req_if.sink   req_bus,
   dws_rsp_if.source rsp_bus,
   dws_csr_if.sink   csr_bus
);

   logic             push_valid, push_ready;
   dws_pkg::cmd_type push_cmd;
   logic             head_valid, pop;
   dws_pkg::cmd_type head_cmd;

   dws_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   dws_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   dws_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

// ===== tb/sv/dws_tb_pkg.sv =====
`timescale 1ns / 1ps
// request function codes shared by the stimulus and the byte stream checker
// no dependencies

package dws_tb_pkg;

   typedef enum logic {
      FUNC_WINDOW = 1'b0,
      FUNC_PIXEL  = 1'b1
   } func_type;

endpackage

// ===== tb/sv/dws_byte_stream_checker.sv =====
`timescale 1ns / 1ps
// watches all three channels of the window write sequencer, predicts the wire bytes
// and compares them in order; depends on dws_pkg, dws_tb_pkg and the channel interfaces

module dws_byte_stream_checker (
   input  logic        clock,
   input  logic        reset,
   dws_req_if          req_bus,
   dws_rsp_if          rsp_bus,
   dws_csr_if          csr_bus,
   output int unsigned mismatch_count,
   output int unsigned bytes_pending,
   output int unsigned bytes_checked
);

   localparam int unsigned MAX_PRINTED = 40;

   typedef struct packed {
      dws_pkg::byte_type wire_byte;
      logic              is_data;
      logic              release_select;
      logic              last_of_run;
   } line_byte_type;

   line_byte_type      expected_bytes[$];
   line_byte_type      want;
   dws_pkg::dim_type   panel_w;
   dws_pkg::dim_type   panel_h;
   dws_pkg::count_type pixels_left;
   int unsigned        mismatches;
   int unsigned        checked;

   task automatic report_mismatch(string field, int unsigned got, int unsigned exp_val);
      mismatches++;
      if (mismatches <= MAX_PRINTED) begin
         $display("%0t ns: byte %0d %s is %0h, predicted %0h", $time, checked, field, got,
                  exp_val);
      end
   endtask

   // command byte, then start and end big-endian, chip select released after the last
   task automatic push_span(dws_pkg::byte_type cmd, int unsigned span_start,
                            int unsigned span_end);
      expected_bytes.push_back(line_byte_type'{cmd, 1'b0, 1'b0, 1'b0});
      expected_bytes.push_back(line_byte_type'{dws_pkg::byte_type'(span_start >> 8), 1'b1,
                                               1'b0, 1'b0});
      expected_bytes.push_back(line_byte_type'{dws_pkg::byte_type'(span_start), 1'b1, 1'b0,
                                               1'b0});
      expected_bytes.push_back(line_byte_type'{dws_pkg::byte_type'(span_end >> 8), 1'b1,
                                               1'b0, 1'b0});
      expected_bytes.push_back(line_byte_type'{dws_pkg::byte_type'(span_end), 1'b1, 1'b1,
                                               1'b0});
   endtask

   task automatic predict_window(dws_pkg::coord_type x, dws_pkg::coord_type y,
                                 dws_pkg::coord_type w, dws_pkg::coord_type h);
      int unsigned xs;
      int unsigned ys;
      int unsigned cols;
      int unsigned rows;
      int unsigned area;
      xs = x;
      ys = y;
      cols = w;
      rows = h;
      if (xs >= panel_w || ys >= panel_h || cols == 0 || rows == 0) return;
      if (xs + cols > panel_w) cols = panel_w - xs;
      if (ys + rows > panel_h) rows = panel_h - ys;
      push_span(dws_pkg::CMD_COL_SET, xs, xs + cols - 1);
      push_span(dws_pkg::CMD_ROW_SET, ys, ys + rows - 1);
      expected_bytes.push_back(line_byte_type'{dws_pkg::CMD_MEM_WR, 1'b0, 1'b0, 1'b1});
      area = cols * rows;
      pixels_left = (area > dws_pkg::COUNT_MAX) ? dws_pkg::COUNT_MAX :
                    dws_pkg::count_type'(area);
   endtask

   task automatic predict_pixel(dws_pkg::pixel_type px);
      if (pixels_left == 0) return;
      pixels_left = pixels_left - 1'b1;
      expected_bytes.push_back(line_byte_type'{px[7:0], 1'b1, 1'b0, 1'b0});
      expected_bytes.push_back(line_byte_type'{px[15:8], 1'b1, pixels_left == 0, 1'b1});
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_bytes.delete();
         panel_w = dws_pkg::PANEL_WIDTH_RESET;
         panel_h = dws_pkg::PANEL_HEIGHT_RESET;
         pixels_left = '0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               dws_pkg::REG_PANEL_WIDTH:  panel_w = csr_bus.data;
               dws_pkg::REG_PANEL_HEIGHT: panel_h = csr_bus.data;
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch("arrived with nothing pending, value", rsp_bus.wire_byte, 0);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_bus.wire_byte !== want.wire_byte)
                  report_mismatch("wire_byte", rsp_bus.wire_byte, want.wire_byte);
               if (rsp_bus.is_data !== want.is_data)
                  report_mismatch("is_data", rsp_bus.is_data, want.is_data);
               if (rsp_bus.release_select !== want.release_select)
                  report_mismatch("release_select", rsp_bus.release_select,
                                  want.release_select);
               if (rsp_bus.last_of_run !== want.last_of_run)
                  report_mismatch("last_of_run", rsp_bus.last_of_run, want.last_of_run);
            end
            checked++;
         end
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.func == dws_tb_pkg::FUNC_PIXEL) begin
               predict_pixel(req_bus.pixel);
            end else begin
               predict_window(req_bus.win_x, req_bus.win_y, req_bus.win_w, req_bus.win_h);
            end
         end
      end
      mismatch_count <= mismatches;
      bytes_pending  <= expected_bytes.size();
      bytes_checked  <= checked;
   end

endmodule

// ===== tb/sv/tb_display_window_write_sequencer.sv =====
`timescale 1ns / 1ps
// stimulus and verdict for the display window write sequencer; checking is done by
// dws_byte_stream_checker; depends on dws_pkg, dws_tb_pkg and the channel interfaces

module tb_display_window_write_sequencer;

   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned SETTLE_CYCLES   = 12;
   localparam int unsigned DRAIN_LIMIT     = 20000;
   localparam dws_pkg::reg_index_type REG_UNUSED_LOW = 8'd2;
   localparam dws_pkg::reg_index_type REG_UNUSED_TOP = 8'hFF;

   typedef enum logic {
      RX_STEADY,
      RX_CHOPPY
   } rx_mode_type;

   logic        clock;
   logic        reset;
   int unsigned mismatch_count;
   int unsigned bytes_pending;
   int unsigned bytes_checked;

   rx_mode_type rx_mode       = RX_CHOPPY;
   logic        hold_off_req  = 1'b0;
   logic        sender_steady = 1'b0;
   int unsigned burst_left    = 0;
   int unsigned windows_sent  = 0;
   int unsigned pixels_sent   = 0;
   int unsigned settings_used = 1;
   int unsigned panel_cols    = dws_pkg::PANEL_WIDTH_RESET;
   int unsigned panel_rows    = dws_pkg::PANEL_HEIGHT_RESET;

   dws_req_if req_bus ();
   dws_rsp_if rsp_bus ();
   dws_csr_if csr_bus ();

   display_window_write_sequencer u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   dws_byte_stream_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_bus        (csr_bus),
      .mismatch_count (mismatch_count),
      .bytes_pending  (bytes_pending),
      .bytes_checked  (bytes_checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("timeout with %0d bytes outstanding", bytes_pending);
      $display("TEST FAILED");
      $finish;
   end

   // output side: steady ready, runs of ready and stalls, or one long hold-off on request
   initial begin : receiver
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (rx_mode == RX_STEADY) begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6))
               @(posedge clock);
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   task automatic offer(dws_tb_pkg::func_type fn, dws_pkg::coord_type x,
                        dws_pkg::coord_type y, dws_pkg::coord_type w, dws_pkg::coord_type h,
                        dws_pkg::pixel_type px);
      req_bus.valid <= 1'b1;
      req_bus.func  <= fn;
      req_bus.win_x <= x;
      req_bus.win_y <= y;
      req_bus.win_w <= w;
      req_bus.win_h <= h;
      req_bus.pixel <= px;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      if (fn == dws_tb_pkg::FUNC_WINDOW) windows_sent++;
      else pixels_sent++;
      if (!sender_steady) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            burst_left = $urandom_range(0, 10);
         end
      end
   endtask

   task automatic send_window(int unsigned x, int unsigned y, int unsigned w, int unsigned h);
      offer(dws_tb_pkg::FUNC_WINDOW, dws_pkg::coord_type'(x), dws_pkg::coord_type'(y),
            dws_pkg::coord_type'(w), dws_pkg::coord_type'(h), dws_pkg::pixel_type'($urandom));
   endtask

   task automatic send_pixel(dws_pkg::pixel_type px);
      offer(dws_tb_pkg::FUNC_PIXEL, dws_pkg::coord_type'($urandom),
            dws_pkg::coord_type'($urandom), dws_pkg::coord_type'($urandom),
            dws_pkg::coord_type'($urandom), px);
   endtask

   task automatic pause_until_drained();
      int unsigned waited;
      waited = 0;
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (bytes_pending != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      // dropped items leave nothing pending but may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(dws_pkg::reg_index_type idx, dws_pkg::dim_type val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      if (idx == dws_pkg::REG_PANEL_WIDTH) panel_cols = val;
      else if (idx == dws_pkg::REG_PANEL_HEIGHT) panel_rows = val;
   endtask

   task automatic set_panel(int unsigned cols, int unsigned rows);
      pause_until_drained();
      write_reg(dws_pkg::REG_PANEL_WIDTH, dws_pkg::dim_type'(cols));
      write_reg(dws_pkg::REG_PANEL_HEIGHT, dws_pkg::dim_type'(rows));
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   // random pixels or full-range windows; the windows are mostly rejected or clipped
   task automatic noise_item();
      if ($urandom_range(0, 2) == 0) begin
         send_pixel(dws_pkg::pixel_type'($urandom));
      end else begin
         send_window($urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 1023), $urandom_range(0, 1023));
      end
   endtask

   task automatic random_phase(int unsigned target);
      int unsigned counted;
      int unsigned x;
      int unsigned y;
      int unsigned w;
      int unsigned h;
      int unsigned n;
      int unsigned k;
      counted = 0;
      while (counted < target) begin
         if ($urandom_range(0, 4) == 0) begin
            sender_steady = 1'b0;
            noise_item();
         end else begin
            sender_steady = ($urandom_range(0, 3) == 0);
            x = $urandom_range(0, panel_cols - 1);
            y = $urandom_range(0, panel_rows - 1);
            w = $urandom_range(1, (panel_cols - x < 4) ? panel_cols - x : 4);
            h = $urandom_range(1, (panel_rows - y < 3) ? panel_rows - y : 3);
            n = w * h;
            case ($urandom_range(0, 7))
               0: k = $urandom_range(0, n - 1);   // cut short, the next window reopens
               1: k = n + 1;                      // one stray pixel after the window
               default: k = n;
            endcase
            send_window(x, y, w, h);
            repeat (k) send_pixel(dws_pkg::pixel_type'($urandom));
            counted += 1 + ((k > n) ? n : k);
         end
      end
      sender_steady = 1'b0;
   endtask

   initial begin : stimulus
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.func  = dws_tb_pkg::FUNC_WINDOW;
      req_bus.win_x = '0;
      req_bus.win_y = '0;
      req_bus.win_w = '0;
      req_bus.win_h = '0;
      req_bus.pixel = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = dws_pkg::REG_PANEL_WIDTH;
      csr_bus.data  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset panel size: stray pixel, single pixel windows, clipping, rejects, reopen
      send_pixel(16'hFFFF);
      send_window(0, 0, 1, 1);
      send_pixel(16'hA55A);
      send_pixel(16'h0000);
      send_window(239, 239, 1023, 1023);
      send_pixel(16'h1234);
      send_window(240, 0, 4, 4);
      send_window(0, 240, 4, 4);
      send_window(10, 10, 0, 5);
      send_window(10, 10, 5, 0);
      send_window(1023, 1023, 1023, 1023);
      send_window(100, 50, 3, 1);
      send_pixel(16'h5AA5);
      send_window(5, 6, 2, 1);
      send_pixel(16'h00FF);
      send_pixel(16'hFF00);
      random_phase(15);

      // largest panel: counter saturates, start columns above 255
      set_panel(511, 511);
      send_window(0, 0, 1023, 1023);
      send_pixel(16'hC3C3);
      send_pixel(16'h3C3C);
      send_window(510, 510, 1, 1);
      send_pixel(16'h8001);
      send_window(300, 400, 40, 200);
      random_phase(12);

      // smallest non-zero panel
      set_panel(1, 1);
      send_window(0, 0, 5, 5);
      send_pixel(16'h7E7E);
      send_window(0, 1, 1, 1);
      send_window(1, 0, 1, 1);
      random_phase(5);

      // zero width rejects every window
      set_panel(0, 200);
      repeat (8) noise_item();

      // writes to unused indexes must leave the panel size alone
      set_panel(320, 320);
      write_reg(REG_UNUSED_LOW, 9'd7);
      write_reg(REG_UNUSED_TOP, 9'd511);
      csr_bus.valid <= 1'b0;
      send_window(319, 319, 1, 1);
      send_pixel(16'h4321);

      // long output hold-off while the sender keeps offering pixels
      rx_mode = RX_STEADY;
      hold_off_req = 1'b1;
      wait (hold_off_req == 1'b0);
      sender_steady = 1'b1;
      send_window(0, 0, 4, 4);
      repeat (16) send_pixel(dws_pkg::pixel_type'($urandom));
      sender_steady = 1'b0;
      rx_mode = RX_CHOPPY;
      pause_until_drained();
      random_phase(15);

      set_panel($urandom_range(1, 511), $urandom_range(1, 511));
      random_phase(12);

      pause_until_drained();
      $display("sent %0d windows and %0d pixels over %0d panel sizes, %0d bytes checked",
               windows_sent, pixels_sent, settings_used, bytes_checked);
      $display("covered clipping, rejects, stray pixels, early reopen, saturation, hold-off");
      if (bytes_pending != 0) $display("%0d predicted bytes never arrived", bytes_pending);
      if (mismatch_count == 0 && bytes_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
